@@ rtl/tccs_pkg.sv @@
// Shared types, constants and codes for the text console.
package tccs_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [7:0] RESET_COLOR = 8'h07;
	localparam logic [7:0] CH_NEWLINE  = 8'd10;
	localparam logic [7:0] CH_TAB      = 8'd9;
	localparam logic [7:0] CH_RETURN   = 8'd13;
	localparam logic [7:0] CH_SPACE    = 8'd32;
	localparam logic [7:0] CH_BLANK    = 8'd0;

	localparam logic [2:0] ACT_PUT   = 3'd0;
	localparam logic [2:0] ACT_BACK  = 3'd1;
	localparam logic [2:0] ACT_CLEAR = 3'd2;
	localparam logic [2:0] ACT_FILL  = 3'd3;
	localparam logic [2:0] ACT_READ  = 3'd4;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_PUT,
		ST_BLANK,
		ST_CLEAR,
		ST_FILL,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] char_code;
		logic [7:0] color;
		logic [6:0] col;
		logic [4:0] row;
	} cmd_t;

	typedef struct packed {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_offset;
		logic [7:0]  read_char;
		logic [7:0]  read_color;
	} res_t;

	typedef logic [7:0] cfg_t;

endpackage

@@ rtl/tccs_stream_if.sv @@
// Valid/ready channel carrying one payload beat.
interface tccs_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/tccs_ram.sv @@
// Generic single-port RAM with registered read.
module tccs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule

@@ rtl/tccs_addr.sv @@
// Maps a screen line and column to a cell address through the scroll ring offset.
module tccs_addr #(
	parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
	input  logic [$clog2(ROWS)-1:0]         line,
	input  logic [$clog2(ROWS)-1:0]         top,
	input  logic [$clog2(COLUMNS)-1:0]      column,
	output logic [$clog2(ROWS*COLUMNS)-1:0] addr
);
	localparam int RW = $clog2(ROWS);
	localparam int AW = $clog2(ROWS * COLUMNS);

	logic [RW:0]   sum;
	logic [RW-1:0] phys;

	always_comb begin
		sum = {1'b0, line} + {1'b0, top};
		if (sum >= (RW+1)'(ROWS)) begin
			sum = sum - (RW+1)'(ROWS);
		end
		phys = sum[RW-1:0];
		addr = AW'(phys) * AW'(COLUMNS) + AW'(column);
	end
endmodule

@@ rtl/text_console_cursor_scroll.sv @@
// Text console top level: command sequencer, cursor, scroll ring and cell stores.
//
// Text console over COLUMNS x ROWS character cells, held in two single-port RAMs
// (character byte and colour byte). Scrolling moves a ring offset for the top line
// instead of copying cells, so a scroll costs one pass over the new bottom line.
// Every command beat gives one result beat with the cursor and its CRTC offset.
// A read waits for the registered RAM read; a tab puts up to four spaces; any
// scroll adds a pass that blanks the bottom line; clear screen and fill colours
// walk every cell. After reset the cell stores are cleared in a pass over every
// cell during which no command is taken; the configuration port is always open.
// Commands are handled one at a time; a finished result waits in an output
// register so the next command can be taken while it is outstanding.
module text_console_cursor_scroll #(
	parameter int COLUMNS = tccs_pkg::COLUMNS_DEF,
	parameter int ROWS    = tccs_pkg::ROWS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	tccs_stream_if.sink   cmd,
	tccs_stream_if.source res,
	tccs_stream_if.sink   cfg
);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);

	tccs_pkg::state_t state_q, state_d;
	tccs_pkg::cmd_t   cmd_q;
	tccs_pkg::res_t   out_q, res_d;

	logic [CW-1:0] col_q, col_d;
	logic [RW-1:0] row_q, row_d;
	logic [RW-1:0] top_q, top_d;
	logic [1:0]    rem_q, rem_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] sweep_q, sweep_d;
	logic          rd_hit_q, rd_hit_d;
	logic          out_valid_q;
	logic          load_out;
	logic [7:0]    default_color_q;

	// shared decode
	logic          col_last, row_last, sweep_last, cnt_last;
	logic          read_in_range, out_free;
	logic          is_tab, is_nl, is_cr;
	logic [7:0]    put_chr;
	logic [RW-1:0] top_inc;

	// memory side
	logic [RW-1:0] a_line;
	logic [CW-1:0] a_col;
	logic [AW-1:0] cell_addr, mem_addr;
	logic          char_we, color_we, mem_re;
	logic [7:0]    char_wdata, color_wdata, char_rdata, color_rdata;
	logic [AW-1:0] offset;

	assign col_last      = (col_q == CW'(COLUMNS - 1));
	assign row_last      = (row_q == RW'(ROWS - 1));
	assign sweep_last    = (sweep_q == AW'(CELLS - 1));
	assign cnt_last      = (cnt_q == CW'(COLUMNS - 1));
	assign read_in_range = (32'(cmd_q.col) < COLUMNS) && (32'(cmd_q.row) < ROWS);
	assign out_free      = !out_valid_q || res.ready;
	assign is_tab        = (cmd_q.char_code == tccs_pkg::CH_TAB);
	assign is_nl         = (cmd_q.char_code == tccs_pkg::CH_NEWLINE);
	assign is_cr         = (cmd_q.char_code == tccs_pkg::CH_RETURN);
	assign put_chr       = is_tab ? tccs_pkg::CH_SPACE : cmd_q.char_code;
	assign top_inc       = (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;

	assign cmd.ready   = (state_q == tccs_pkg::ST_IDLE);
	assign cfg.ready   = 1'b1;
	assign res.valid   = out_valid_q;
	assign res.payload = out_q;

	// next state and cursor
	always_comb begin
		logic       finish;
		logic       advance;
		logic [1:0] rem_after;

		state_d   = state_q;
		col_d     = col_q;
		row_d     = row_q;
		top_d     = top_q;
		rem_d     = rem_q;
		cnt_d     = cnt_q;
		sweep_d   = sweep_q;
		rd_hit_d  = rd_hit_q;
		finish    = 1'b0;
		advance   = 1'b0;
		rem_after = '0;
		load_out  = 1'b0;

		case (state_q)
			tccs_pkg::ST_INIT: begin
				sweep_d = sweep_q + 1'b1;
				if (sweep_last) begin
					sweep_d = '0;
					state_d = tccs_pkg::ST_IDLE;
				end
			end
			tccs_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					state_d = tccs_pkg::ST_EXEC;
				end
			end
			tccs_pkg::ST_EXEC: begin
				rd_hit_d = 1'b0;
				case (cmd_q.action)
					tccs_pkg::ACT_PUT: begin
						if (is_nl) begin
							col_d = '0;
							if (row_last) begin
								top_d   = top_inc;
								cnt_d   = '0;
								rem_d   = '0;
								state_d = tccs_pkg::ST_BLANK;
							end else begin
								row_d  = row_q + 1'b1;
								finish = 1'b1;
							end
						end else if (is_cr) begin
							col_d  = '0;
							finish = 1'b1;
						end else begin
							// tab: 4 - col%4 spaces, first one written now
							advance   = 1'b1;
							rem_after = is_tab ? ~col_q[1:0] : 2'd0;
						end
					end
					tccs_pkg::ACT_BACK: begin
						if (col_q != '0) begin
							col_d = col_q - 1'b1;
						end
						finish = 1'b1;
					end
					tccs_pkg::ACT_CLEAR: begin
						col_d   = '0;
						row_d   = '0;
						top_d   = '0;
						sweep_d = '0;
						state_d = tccs_pkg::ST_CLEAR;
					end
					tccs_pkg::ACT_FILL: begin
						sweep_d = '0;
						state_d = tccs_pkg::ST_FILL;
					end
					tccs_pkg::ACT_READ: begin
						if (read_in_range) begin
							rd_hit_d = 1'b1;
							state_d  = tccs_pkg::ST_READ;
						end else begin
							finish = 1'b1;
						end
					end
					default: begin
						finish = 1'b1;
					end
				endcase
			end
			tccs_pkg::ST_PUT: begin
				advance   = 1'b1;
				rem_after = rem_q - 1'b1;
			end
			tccs_pkg::ST_BLANK: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_last) begin
					cnt_d = '0;
					if (rem_q != '0) begin
						state_d = tccs_pkg::ST_PUT;
					end else begin
						finish = 1'b1;
					end
				end
			end
			tccs_pkg::ST_CLEAR, tccs_pkg::ST_FILL: begin
				sweep_d = sweep_q + 1'b1;
				if (sweep_last) begin
					sweep_d = '0;
					finish  = 1'b1;
				end
			end
			tccs_pkg::ST_READ: begin
				finish = 1'b1;
			end
			tccs_pkg::ST_DONE: begin
				finish = 1'b1;
			end
			default: begin
				state_d = tccs_pkg::ST_IDLE;
			end
		endcase

		// cursor step after a written character, with wrap and scroll
		if (advance) begin
			rem_d = rem_after;
			if (col_last) begin
				col_d = '0;
				if (row_last) begin
					top_d   = top_inc;
					cnt_d   = '0;
					state_d = tccs_pkg::ST_BLANK;
				end else begin
					row_d = row_q + 1'b1;
				end
			end else begin
				col_d = col_q + 1'b1;
			end
			if (!(col_last && row_last)) begin
				if (rem_after != '0) begin
					state_d = tccs_pkg::ST_PUT;
				end else begin
					finish = 1'b1;
				end
			end
		end

		if (finish) begin
			if (out_free) begin
				load_out = 1'b1;
				state_d  = tccs_pkg::ST_IDLE;
			end else begin
				state_d = tccs_pkg::ST_DONE;
			end
		end
	end

	// memory controls and result beat
	always_comb begin
		a_line      = row_q;
		a_col       = col_q;
		char_we     = 1'b0;
		color_we    = 1'b0;
		mem_re      = 1'b0;
		char_wdata  = tccs_pkg::CH_BLANK;
		color_wdata = default_color_q;

		case (state_q)
			tccs_pkg::ST_INIT: begin
				char_we     = 1'b1;
				color_we    = 1'b1;
				color_wdata = tccs_pkg::RESET_COLOR;
			end
			tccs_pkg::ST_EXEC: begin
				case (cmd_q.action)
					tccs_pkg::ACT_PUT: begin
						char_we    = !is_nl && !is_cr;
						char_wdata = put_chr;
					end
					tccs_pkg::ACT_BACK: begin
						a_col      = col_q - 1'b1;
						char_we    = (col_q != '0);
						char_wdata = tccs_pkg::CH_SPACE;
					end
					tccs_pkg::ACT_READ: begin
						a_line = RW'(cmd_q.row);
						a_col  = CW'(cmd_q.col);
						mem_re = read_in_range;
					end
					default: begin
						char_we = 1'b0;
					end
				endcase
			end
			tccs_pkg::ST_PUT: begin
				char_we    = 1'b1;
				char_wdata = put_chr;
			end
			tccs_pkg::ST_BLANK: begin
				// ring offset already moved: bottom line is the old top line
				a_line   = RW'(ROWS - 1);
				a_col    = cnt_q;
				char_we  = 1'b1;
				color_we = 1'b1;
			end
			tccs_pkg::ST_CLEAR: begin
				char_we  = 1'b1;
				color_we = 1'b1;
			end
			tccs_pkg::ST_FILL: begin
				color_we    = 1'b1;
				color_wdata = cmd_q.color;
			end
			default: begin
				char_we = 1'b0;
			end
		endcase

		mem_addr = cell_addr;
		if (state_q == tccs_pkg::ST_INIT || state_q == tccs_pkg::ST_CLEAR ||
		    state_q == tccs_pkg::ST_FILL) begin
			mem_addr = sweep_q;
		end

		offset              = AW'(row_d) * AW'(COLUMNS) + AW'(col_d);
		res_d.cursor_col    = 7'(col_d);
		res_d.cursor_row    = 5'(row_d);
		res_d.cursor_offset = 11'(offset);
		if (rd_hit_q && state_q != tccs_pkg::ST_EXEC) begin
			res_d.read_char  = char_rdata;
			res_d.read_color = color_rdata;
		end else begin
			res_d.read_char  = '0;
			res_d.read_color = '0;
		end
	end

	tccs_addr #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_addr (
		.line   (a_line),
		.top    (top_q),
		.column (a_col),
		.addr   (cell_addr)
	);

	tccs_ram #(
		.WIDTH (8),
		.DEPTH (CELLS)
	) u_char_ram (
		.clk   (clk),
		.we    (char_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (char_wdata),
		.rdata (char_rdata)
	);

	tccs_ram #(
		.WIDTH (8),
		.DEPTH (CELLS)
	) u_color_ram (
		.clk   (clk),
		.we    (color_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (color_wdata),
		.rdata (color_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= tccs_pkg::ST_INIT;
			col_q           <= '0;
			row_q           <= '0;
			top_q           <= '0;
			rem_q           <= '0;
			cnt_q           <= '0;
			sweep_q         <= '0;
			rd_hit_q        <= 1'b0;
			out_valid_q     <= 1'b0;
			default_color_q <= tccs_pkg::RESET_COLOR;
		end else begin
			state_q  <= state_d;
			col_q    <= col_d;
			row_q    <= row_d;
			top_q    <= top_d;
			rem_q    <= rem_d;
			cnt_q    <= cnt_d;
			sweep_q  <= sweep_d;
			rd_hit_q <= rd_hit_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				default_color_q <= cfg.payload;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_q <= cmd.payload;
		end
		if (load_out) begin
			out_q <= res_d;
		end
	end
endmodule
